// File: design/sha_pkg.sv
// SHA-256 hasher package: item types, round constants, initial hash values
// and the round/schedule helper functions. No dependencies.
`timescale 1ns / 1ps
package sha_pkg;

  localparam int unsigned BytesPerItem = 8;
  localparam int unsigned RoundCount   = 64;

  typedef struct packed {
    logic [63:0] message_bytes;
    logic [3:0]  byte_count;
    logic        end_of_message;
  } sha_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } sha_out_t;

  function automatic logic [31:0] init_hash(input logic [2:0] i);
    logic [31:0] r;
    case (i)
      3'd0: r = 32'h6a09e667;
      3'd1: r = 32'hbb67ae85;
      3'd2: r = 32'h3c6ef372;
      3'd3: r = 32'ha54ff53a;
      3'd4: r = 32'h510e527f;
      3'd5: r = 32'h9b05688c;
      3'd6: r = 32'h1f83d9ab;
      default: r = 32'h5be0cd19;
    endcase
    return r;
  endfunction

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

// File: design/sha_wstore.sv
// Message word store: 16 x 32-bit synchronous RAM that holds the block and
// then the rolling schedule. No dependencies.
`timescale 1ns / 1ps
module sha_wstore (
  input  logic        clk_i,
  input  logic        we_i,
  input  logic [3:0]  waddr_i,
  input  logic [31:0] wdata_i,
  input  logic [3:0]  raddr_i,
  output logic [31:0] rdata_o
);
  logic [31:0] mem [16];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

// File: design/sha_round.sv
// Compression datapath: one SHA-256 round per cycle while round_i is high,
// on working variables, and the final add into hash words. Depends on sha_pkg.
`timescale 1ns / 1ps
module sha_round (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        round_i,
  input  logic [5:0]  t_i,
  input  logic [31:0] w_i,
  input  logic        fold_i,
  input  logic        reinit_i,
  input  logic [2:0]  rd_idx_i,
  output logic [31:0] hash_o
);
  import sha_pkg::*;

  logic [31:0] h_q [8];
  logic [31:0] v_q [8];
  logic [31:0] s1, ch, s0, mj, p, q;

  always_comb begin
    s1 = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
    ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    s0 = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
    mj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    p  = v_q[7] + s1 + ch + RoundK[t_i] + w_i;
    q  = s0 + mj;
  end

  // hash state: initial values on reset or reinit, fold after 64 rounds
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) h_q[i] <= init_hash(3'(i));
    end else if (reinit_i) begin
      for (int i = 0; i < 8; i++) h_q[i] <= init_hash(3'(i));
    end else if (fold_i) begin
      for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
    end
  end

  // working variables
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
    end else if (round_i) begin
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + p;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= p + q;
    end
  end

  assign hash_o = h_q[rd_idx_i];
endmodule

// File: design/sha256_message_hasher.sv
// SHA-256 message hasher top level: byte packing, padding, schedule sequencer
// and digest output. Depends on sha_pkg, sha_wstore, sha_round.
`timescale 1ns / 1ps
// Items are taken one at a time. An accepted item is registered in S_IDLE, then
// its bytes are packed into the word store at one byte per cycle, except while
// a full block is compressed (an item with no bytes writes nothing). When a
// 64-byte block fills, it is compressed before any further byte is taken: a load
// step, 64 round steps that each make four reads of the single-read-port word
// store, w[t-2], w[t-7], w[t-15] and w[t], with the new schedule word written
// back in the fourth, and a fold step. The final item adds padding at one byte
// per cycle (one or two blocks, each followed by a compression) and then emits
// eight digest words, one per accepted output item; after the last word the
// block is back at its reset state.
module sha256_message_hasher (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sha_pkg::sha_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output sha_pkg::sha_out_t out_data_o
);
  import sha_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_FEED = 7'b0000010,
    S_PAD  = 7'b0000100,
    S_LOAD = 7'b0001000,
    S_RND  = 7'b0010000,
    S_FOLD = 7'b0100000,
    S_OUT  = 7'b1000000
  } st_e;

  st_e         st_q, st_d;
  logic [63:0] data_q;
  logic [3:0]  cnt_q;
  logic        last_q;
  logic [5:0]  fill_q;
  logic [60:0] total_q;
  logic [31:0] acc_q;
  logic        pad_done_q;
  // length bytes written once the last block's bytes 56..63 are placed
  logic        len_done_q;
  // pad byte landed in 56..62: this block is zero filled, length goes next
  logic        spill_q;
  logic [5:0]  t_q;
  logic [1:0]  ph_q;
  logic [31:0] w2_q, w7_q, w15_q;
  logic [2:0]  oidx_q;

  logic        we;
  logic [3:0]  waddr, raddr;
  logic [31:0] wdata, rdata, wcur, hash;
  logic        start, rnd, fold, reinit;
  logic [7:0]  byte_v;
  logic        put, post_fill;
  logic [63:0] bits;

  assign bits = {total_q, 3'b000};

  sha_wstore u_ws (.clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
                   .raddr_i(raddr), .rdata_o(rdata));

  sha_round u_rnd (.clk_i, .rst_ni, .start_i(start), .round_i(rnd), .t_i(t_q),
                   .w_i(wcur), .fold_i(fold), .reinit_i(reinit),
                   .rd_idx_i(oidx_q), .hash_o(hash));

  assign in_ready_o  = (st_q == S_IDLE);
  assign out_valid_o = (st_q == S_OUT);
  assign out_data_o  = '{digest_word: hash, word_index: oidx_q,
                         last_word: (oidx_q == 3'd7)};

  // byte source: item byte while feeding, else pad byte / zero / length
  always_comb begin
    byte_v = 8'h00;
    put    = 1'b0;
    if (st_q == S_FEED) begin
      byte_v = data_q[63:56];
      put    = (cnt_q != 4'd0);
    end else if (st_q == S_PAD) begin
      put = 1'b1;
      if (!pad_done_q) byte_v = 8'h80;
      else if (fill_q >= 6'd56 && !spill_q) byte_v = bits[{~fill_q[2:0], 3'b111} -: 8];
      else byte_v = 8'h00;
    end
  end

  // schedule: round t<16 reads w[t]; later rounds read t-2,t-7,t-15,t
  logic [31:0] s0w, s1w, wnew;
  assign s1w  = rotr(w2_q, 17) ^ rotr(w2_q, 19) ^ (w2_q >> 10);
  assign s0w  = rotr(w15_q, 7) ^ rotr(w15_q, 18) ^ (w15_q >> 3);
  assign wnew = s1w + w7_q + s0w + rdata;
  assign wcur = (t_q < 6'd16) ? rdata : wnew;

  // reads are issued one phase ahead; w[t-2] of the next round goes out in phase 3
  always_comb begin
    raddr = t_q[3:0];
    case (ph_q)
      2'd0: raddr = t_q[3:0] - 4'd7;
      2'd1: raddr = t_q[3:0] - 4'd15;
      2'd2: raddr = t_q[3:0];
      default: raddr = t_q[3:0] - 4'd1;
    endcase
    if (st_q != S_RND) raddr = 4'd0;
  end

  // word store write: packed bytes, or new schedule word
  always_comb begin
    we    = 1'b0;
    waddr = fill_q[5:2];
    wdata = {acc_q[23:0], byte_v};
    if (put && fill_q[1:0] == 2'd3) we = 1'b1;
    if (st_q == S_RND && ph_q == 2'd3 && t_q >= 6'd16) begin
      we    = 1'b1;
      waddr = t_q[3:0];
      wdata = wnew;
    end
  end

  assign post_fill = put && (fill_q == 6'd63);
  assign rnd       = (st_q == S_RND) && (ph_q == 2'd3);
  assign start     = (st_q == S_LOAD);
  assign fold      = (st_q == S_FOLD);
  assign reinit    = (st_q == S_OUT) && out_ready_i && (oidx_q == 3'd7);

  // sequencer
  always_comb begin
    st_d = st_q;
    case (st_q)
      S_IDLE: if (in_valid_i) st_d = S_FEED;
      S_FEED: begin
        if (post_fill) st_d = S_LOAD;
        else if (cnt_q <= 4'd1) st_d = last_q ? S_PAD : S_IDLE;
      end
      S_PAD: begin
        if (post_fill) st_d = S_LOAD;
      end
      S_LOAD: st_d = S_RND;
      S_RND: if (ph_q == 2'd3 && t_q == 6'd63) st_d = S_FOLD;
      S_FOLD: begin
        if (cnt_q != 4'd0) st_d = S_FEED;
        else if (!last_q) st_d = S_IDLE;
        else if (pad_done_q && len_done_q) st_d = S_OUT;
        else st_d = S_PAD;
      end
      S_OUT: if (out_ready_i && oidx_q == 3'd7) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= S_IDLE;
      fill_q     <= '0;
      total_q    <= '0;
      cnt_q      <= '0;
      last_q     <= 1'b0;
      pad_done_q <= 1'b0;
      len_done_q <= 1'b0;
      spill_q    <= 1'b0;
      t_q        <= '0;
      ph_q       <= '0;
      oidx_q     <= '0;
    end else begin
      st_q <= st_d;
      if (st_q == S_IDLE && in_valid_i) begin
        cnt_q  <= (in_data_i.byte_count > 4'(BytesPerItem)) ? 4'(BytesPerItem)
                                                             : in_data_i.byte_count;
        last_q <= in_data_i.end_of_message;
      end
      if (put) fill_q <= fill_q + 6'd1;
      if (st_q == S_FEED && cnt_q != 4'd0) begin
        cnt_q   <= cnt_q - 4'd1;
        total_q <= total_q + 61'd1;
      end
      if (st_q == S_PAD) begin
        pad_done_q <= 1'b1;
        if (!pad_done_q) spill_q <= (fill_q >= 6'd56) && (fill_q != 6'd63);
        else if (post_fill) spill_q <= 1'b0;
        if (post_fill && pad_done_q && !spill_q) len_done_q <= 1'b1;
      end
      if (st_q == S_LOAD) begin
        t_q  <= '0;
        ph_q <= '0;
      end else if (st_q == S_RND) begin
        ph_q <= ph_q + 2'd1;
        if (ph_q == 2'd3) t_q <= t_q + 6'd1;
      end
      if (st_q == S_OUT && out_ready_i) begin
        oidx_q <= oidx_q + 3'd1;
        if (oidx_q == 3'd7) begin
          fill_q     <= '0;
          total_q    <= '0;
          pad_done_q <= 1'b0;
          len_done_q <= 1'b0;
          spill_q    <= 1'b0;
          last_q     <= 1'b0;
        end
      end
    end
  end

  // payload: item shift register, byte accumulator, schedule operands
  always_ff @(posedge clk_i) begin
    if (st_q == S_IDLE && in_valid_i) data_q <= in_data_i.message_bytes;
    else if (st_q == S_FEED) data_q <= {data_q[55:0], 8'h00};
    if (put) acc_q <= {acc_q[23:0], byte_v};
    if (st_q == S_RND) begin
      case (ph_q)
        2'd0: w2_q  <= rdata;
        2'd1: w7_q  <= rdata;
        2'd2: w15_q <= rdata;
        default: ;
      endcase
    end
  end
endmodule
